@@ design/pfi_pkg.sv @@
// ---------------------------------------------------------------------------
// pfi_pkg
// shared types and constants of the palette fade interpolator
// ---------------------------------------------------------------------------
package pfi_pkg;

  localparam int VALUE_W = 16;
  localparam int COLOR_W = 12;
  localparam int CFG_W   = 15;

  localparam logic [COLOR_W-1:0] COLOR_MASK = 12'h0EEE;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_FRAME = 2'd2;

  localparam logic [1:0] CFG_FIRST_INDEX = 2'd0;
  localparam logic [1:0] CFG_COLOR_COUNT = 2'd1;
  localparam logic [1:0] CFG_FRAME_COUNT = 2'd2;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIV  = 6'b000010,
    ST_LWR  = 6'b000100,
    ST_ACC  = 6'b001000,
    ST_EMIT = 6'b010000,
    ST_REJ  = 6'b100000
  } state_t;

endpackage

@@ design/pfi_ram.sv @@
// ---------------------------------------------------------------------------
// pfi_ram
// generic simple dual-port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
module pfi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 192
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/palette_fade_interpolator_unit.sv @@
// ---------------------------------------------------------------------------
// palette_fade_interpolator_unit
// linear fade of a run of packed 9-bit colors in fixed point
// ---------------------------------------------------------------------------
// input transactions (in_valid/in_stall) carry a mode: load one entry,
// start a fade or advance one frame. configuration is written through
// cfg_wr_en/cfg_index/cfg_wr_data; the user must write it only while the
// block is idle, the block itself does not enforce this. a load runs one
// shared restoring divider, one quotient bit per cycle for each channel
// step, then writes the value and step rams for that channel.
// start and frame transactions walk the run through the value and step
// rams, one channel per cycle through one adder; each color then goes to
// ST_EMIT, which waits while the output register is stalled. a rejected
// start gives one result. in_stall is high while a transaction is in work.
// results (out_valid/out_stall) sit in an output register; a stalled
// receiver holds the sequencer at the current color, nothing is lost.
// reset (rst_n low, synchronous) clears the sequencer, output valid,
// frame counter and config (color count to 64); rams stay undefined.
// ---------------------------------------------------------------------------
module palette_fade_interpolator_unit #(
  parameter int MAX_COLORS = 64,
  parameter int FRAC_BITS  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [5:0]  in_entry_index,
  input  logic [11:0] in_source_color,
  input  logic [11:0] in_target_color,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_color_index,
  output logic [11:0] out_color,
  output logic        out_last,
  output logic        out_more_frames,
  output logic        out_status
);

  localparam int VW    = pfi_pkg::VALUE_W;
  localparam int DEPTH = 3 * MAX_COLORS;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(MAX_COLORS);
  localparam int DW    = FRAC_BITS + 3;
  localparam int CW    = $clog2(DW + 1);
  localparam logic [VW-1:0] BIAS = VW'((1 << (FRAC_BITS - 1)) - 1);

  pfi_pkg::state_t state_r, state_nxt;

  logic [5:0]        first_index_r;
  logic [6:0]        color_count_r;
  logic [14:0]       frame_count_r;
  logic [14:0]       frames_left_r, frames_left_nxt;

  logic [1:0]        chan_r, chan_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic [PW-1:0]     pos_r, pos_nxt;
  logic [PW-1:0]     last_pos_r, last_pos_nxt;
  logic [5:0]        idx_r, idx_nxt;
  logic              add_r, add_nxt;
  logic              more_r, more_nxt;
  logic [11:0]       src_r, src_nxt;
  logic [11:0]       dst_r, dst_nxt;
  logic [2:0]        s_ch_r, s_ch_nxt;
  logic              neg_r, neg_nxt;
  logic [DW-1:0]     dvd_r, dvd_nxt;
  logic [VW-1:0]     rem_r, rem_nxt;
  logic [DW-1:0]     quo_r, quo_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [2:0][2:0]   chan_bits_r, chan_bits_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [5:0]        out_index_r, out_index_nxt;
  logic [11:0]       out_color_r, out_color_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_more_r, out_more_nxt;
  logic              out_status_r, out_status_nxt;

  logic              in_accept;
  logic              out_free;
  logic              val_we;
  logic [VW-1:0]     val_wdata;
  logic              step_we;
  logic [VW-1:0]     step_wdata;
  logic [VW-1:0]     val_rdata;
  logic [VW-1:0]     step_rdata;
  logic [VW-1:0]     acc_sum;

  logic [11:0]       init_src;
  logic [11:0]       init_dst;
  logic [1:0]        init_chan;
  logic [2:0]        init_s;
  logic [2:0]        init_d;
  logic [2:0]        init_mag;
  logic              init_neg;

  logic [VW-1:0]     div_trial;
  logic              div_ge;

  function automatic logic [2:0] chan_of(input logic [11:0] c, input logic [1:0] k);
    logic [2:0] r;
    case (k)
      pfi_pkg::CH_RED:   r = c[3:1];
      pfi_pkg::CH_GREEN: r = c[7:5];
      default:           r = c[11:9];
    endcase
    return r;
  endfunction

  assign in_stall  = (state_r != pfi_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // divider setup for the next channel
  always_comb begin
    if (state_r == pfi_pkg::ST_IDLE) begin
      init_src  = in_source_color;
      init_dst  = in_target_color;
      init_chan = pfi_pkg::CH_RED;
    end else begin
      init_src  = src_r;
      init_dst  = dst_r;
      init_chan = chan_r + 2'd1;
    end
    init_s   = chan_of(init_src, init_chan);
    init_d   = chan_of(init_dst, init_chan);
    init_neg = (init_s > init_d);
    init_mag = init_neg ? (init_s - init_d) : (init_d - init_s);
  end

  assign div_trial = {rem_r[VW-2:0], dvd_r[DW-1]};
  assign div_ge    = (div_trial >= {1'b0, frame_count_r});
  assign acc_sum   = add_r ? (val_rdata + step_rdata) : val_rdata;

  always_comb begin
    state_nxt       = state_r;
    frames_left_nxt = frames_left_r;
    chan_nxt        = chan_r;
    addr_nxt        = addr_r;
    pos_nxt         = pos_r;
    last_pos_nxt    = last_pos_r;
    idx_nxt         = idx_r;
    add_nxt         = add_r;
    more_nxt        = more_r;
    src_nxt         = src_r;
    dst_nxt         = dst_r;
    s_ch_nxt        = s_ch_r;
    neg_nxt         = neg_r;
    dvd_nxt         = dvd_r;
    rem_nxt         = rem_r;
    quo_nxt         = quo_r;
    cnt_nxt         = cnt_r;
    chan_bits_nxt   = chan_bits_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_index_nxt   = out_index_r;
    out_color_nxt   = out_color_r;
    out_last_nxt    = out_last_r;
    out_more_nxt    = out_more_r;
    out_status_nxt  = out_status_r;
    val_we          = 1'b0;
    val_wdata       = acc_sum;
    step_we         = 1'b0;
    step_wdata      = '0;

    case (state_r)
      pfi_pkg::ST_IDLE: begin
        if (in_accept) begin
          case (in_mode)
            pfi_pkg::MODE_LOAD: begin
              if (32'(in_entry_index) < MAX_COLORS) begin
                src_nxt  = in_source_color;
                dst_nxt  = in_target_color;
                chan_nxt = pfi_pkg::CH_RED;
                addr_nxt = AW'(9'({in_entry_index, 1'b0}) + 9'(in_entry_index));
                s_ch_nxt = init_s;
                neg_nxt  = init_neg;
                dvd_nxt  = {init_mag, FRAC_BITS'(0)};
                rem_nxt  = '0;
                quo_nxt  = '0;
                cnt_nxt  = CW'(DW);
                state_nxt = pfi_pkg::ST_DIV;
              end
            end
            pfi_pkg::MODE_START, pfi_pkg::MODE_FRAME: begin
              if (in_mode == pfi_pkg::MODE_START && frame_count_r == '0) begin
                state_nxt = pfi_pkg::ST_REJ;
              end else begin
                if (in_mode == pfi_pkg::MODE_START) begin
                  frames_left_nxt = frame_count_r;
                  add_nxt         = 1'b0;
                  more_nxt        = 1'b1;
                end else begin
                  if (frames_left_r != '0) begin
                    frames_left_nxt = frames_left_r - 15'd1;
                  end
                  add_nxt  = 1'b1;
                  more_nxt = (frames_left_r > 15'd1);
                end
                if (color_count_r == '0) begin
                  last_pos_nxt = '0;
                end else if (32'(color_count_r) > MAX_COLORS) begin
                  last_pos_nxt = PW'(MAX_COLORS - 1);
                end else begin
                  last_pos_nxt = PW'(color_count_r - 7'd1);
                end
                chan_nxt  = pfi_pkg::CH_RED;
                addr_nxt  = '0;
                pos_nxt   = '0;
                idx_nxt   = first_index_r;
                state_nxt = pfi_pkg::ST_ACC;
              end
            end
            default: begin
            end
          endcase
        end
      end
      pfi_pkg::ST_DIV: begin
        rem_nxt = div_ge ? (div_trial - {1'b0, frame_count_r}) : div_trial;
        quo_nxt = {quo_r[DW-2:0], div_ge};
        dvd_nxt = dvd_r << 1;
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          state_nxt = pfi_pkg::ST_LWR;
        end
      end
      pfi_pkg::ST_LWR: begin
        val_we    = 1'b1;
        val_wdata = VW'({s_ch_r, FRAC_BITS'(0)}) + BIAS;
        step_we   = 1'b1;
        if (frame_count_r == '0) begin
          step_wdata = '0;
        end else if (neg_r) begin
          step_wdata = VW'(0) - VW'(quo_r);
        end else begin
          step_wdata = VW'(quo_r);
        end
        if (chan_r == pfi_pkg::CH_BLUE) begin
          state_nxt = pfi_pkg::ST_IDLE;
        end else begin
          chan_nxt  = chan_r + 2'd1;
          addr_nxt  = addr_r + AW'(1);
          s_ch_nxt  = init_s;
          neg_nxt   = init_neg;
          dvd_nxt   = {init_mag, FRAC_BITS'(0)};
          rem_nxt   = '0;
          quo_nxt   = '0;
          cnt_nxt   = CW'(DW);
          state_nxt = pfi_pkg::ST_DIV;
        end
      end
      pfi_pkg::ST_ACC: begin
        val_we                = add_r;
        chan_bits_nxt[chan_r] = acc_sum[FRAC_BITS+2:FRAC_BITS];
        addr_nxt              = addr_r + AW'(1);
        if (chan_r == pfi_pkg::CH_BLUE) begin
          chan_nxt  = pfi_pkg::CH_RED;
          state_nxt = pfi_pkg::ST_EMIT;
        end else begin
          chan_nxt = chan_r + 2'd1;
        end
      end
      pfi_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_index_nxt  = idx_r;
          out_color_nxt  = {chan_bits_r[2], 1'b0, chan_bits_r[1], 1'b0,
                            chan_bits_r[0], 1'b0};
          out_last_nxt   = (pos_r == last_pos_r);
          out_more_nxt   = more_r;
          out_status_nxt = 1'b0;
          if (pos_r == last_pos_r) begin
            state_nxt = pfi_pkg::ST_IDLE;
          end else begin
            pos_nxt   = pos_r + PW'(1);
            idx_nxt   = idx_r + 6'd1;
            state_nxt = pfi_pkg::ST_ACC;
          end
        end
      end
      pfi_pkg::ST_REJ: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_index_nxt  = first_index_r;
          out_color_nxt  = '0;
          out_last_nxt   = 1'b1;
          out_more_nxt   = 1'b0;
          out_status_nxt = 1'b1;
          state_nxt      = pfi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pfi_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= pfi_pkg::ST_IDLE;
      out_valid_r   <= 1'b0;
      frames_left_r <= '0;
      first_index_r <= '0;
      color_count_r <= 7'd64;
      frame_count_r <= '0;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      frames_left_r <= frames_left_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          pfi_pkg::CFG_FIRST_INDEX: first_index_r <= cfg_wr_data[5:0];
          pfi_pkg::CFG_COLOR_COUNT: color_count_r <= cfg_wr_data[6:0];
          pfi_pkg::CFG_FRAME_COUNT: frame_count_r <= cfg_wr_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    chan_r       <= chan_nxt;
    addr_r       <= addr_nxt;
    pos_r        <= pos_nxt;
    last_pos_r   <= last_pos_nxt;
    idx_r        <= idx_nxt;
    add_r        <= add_nxt;
    more_r       <= more_nxt;
    src_r        <= src_nxt;
    dst_r        <= dst_nxt;
    s_ch_r       <= s_ch_nxt;
    neg_r        <= neg_nxt;
    dvd_r        <= dvd_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    cnt_r        <= cnt_nxt;
    chan_bits_r  <= chan_bits_nxt;
    out_index_r  <= out_index_nxt;
    out_color_r  <= out_color_nxt;
    out_last_r   <= out_last_nxt;
    out_more_r   <= out_more_nxt;
    out_status_r <= out_status_nxt;
  end

  // read address runs one step ahead so data lines up with addr_r
  pfi_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_value_ram (
    .clk     (clk),
    .wr_en   (val_we),
    .wr_addr (addr_r),
    .wr_data (val_wdata),
    .rd_addr (addr_nxt),
    .rd_data (val_rdata)
  );

  pfi_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_step_ram (
    .clk     (clk),
    .wr_en   (step_we),
    .wr_addr (addr_r),
    .wr_data (step_wdata),
    .rd_addr (addr_nxt),
    .rd_data (step_rdata)
  );

  assign out_valid       = out_valid_r;
  assign out_color_index = out_index_r;
  assign out_color       = out_color_r;
  assign out_last        = out_last_r;
  assign out_more_frames = out_more_r;
  assign out_status      = out_status_r;

  a_frame_countdown: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_mode == pfi_pkg::MODE_FRAME && frames_left_r != '0)
    |=> (frames_left_r == $past(frames_left_r) - 15'd1))
    else $error("frame counter did not count down");

  a_reject_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_last && !out_more_frames))
    else $error("rejected start not a single final result");

  a_color_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_color & ~pfi_pkg::COLOR_MASK) == '0))
    else $error("color has bits outside the channel fields");

  a_emit_chan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pfi_pkg::ST_EMIT) |-> (chan_r == pfi_pkg::CH_RED))
    else $error("channel sequence out of step at emit");

endmodule

@@ tb/tb_palette_fade_interpolator_unit.sv @@
// ---------------------------------------------------------------------------
// tb_palette_fade_interpolator_unit
// self-checking regression of the palette fade interpolator
// ---------------------------------------------------------------------------
// Drives load, start and frame transactions through the valid/stall input
// channel and checks every emitted color against an in-bench fade predictor
// that keeps its own 8.8 channel values, steps and frame counter. Each phase
// reprograms the run (first index, color count, frame count) while the block
// is idle, loads every entry of the run, starts the fade and sends frames,
// past its end for short fades. Some noise is mixed in: ignored mode 3
// transactions, stray loads, restarts and skipped starts. Both channels idle
// at random, apart from one long stretch of back-to-back traffic.
// ---------------------------------------------------------------------------
module tb_palette_fade_interpolator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 8;
  localparam int RUN_MAX = 64;
  localparam logic [15:0] ROUND_BIAS = 16'((1 << (FRAC - 1)) - 1);
  localparam logic [1:0] MODE_IGNORED = 2'd3;
  localparam int ITEM_TARGET = 260;
  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic [5:0]  color_index;
    logic [11:0] color;
    logic        last;
    logic        more_frames;
    logic        status;
  } fade_color_t;

  class fade_scoreboard;
    logic [15:0] chan_value [3*RUN_MAX];
    logic [15:0] chan_step [3*RUN_MAX];
    logic [14:0] frames_left;
    logic [5:0]  first_index;
    logic [6:0]  color_count;
    logic [14:0] frame_count;
    fade_color_t colors_due[$];
    int          mismatches;

    function new();
      foreach (chan_value[e]) begin
        chan_value[e] = '0;
        chan_step[e]  = '0;
      end
      frames_left = '0;
      first_index = '0;
      color_count = 7'd64;
      frame_count = '0;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [14:0] data);
      case (idx)
        pfi_pkg::CFG_FIRST_INDEX: first_index = data[5:0];
        pfi_pkg::CFG_COLOR_COUNT: color_count = data[6:0];
        pfi_pkg::CFG_FRAME_COUNT: frame_count = data;
        default: ;
      endcase
    endfunction

    function int run_length();
      if (color_count == 0) return 1;
      if (color_count > RUN_MAX) return RUN_MAX;
      return int'(color_count);
    endfunction

    function logic [11:0] packed_color(int pos);
      logic [11:0] c;
      c = '0;
      for (int k = 0; k < 3; k++) begin
        c |= 12'(chan_value[pos*3+k][FRAC+2:FRAC]) << (4*k + 1);
      end
      return c & pfi_pkg::COLOR_MASK;
    endfunction

    function void queue_run(bit advance, logic more);
      int n;
      fade_color_t r;
      n = run_length();
      for (int i = 0; i < n; i++) begin
        if (advance) begin
          for (int k = 0; k < 3; k++) begin
            chan_value[i*3+k] = chan_value[i*3+k] + chan_step[i*3+k];
          end
        end
        r.color_index = first_index + 6'(i);
        r.color       = packed_color(i);
        r.last        = (i == n - 1);
        r.more_frames = more;
        r.status      = 1'b0;
        colors_due.push_back(r);
      end
    endfunction

    function void note_input(logic [1:0] mode, logic [5:0] entry,
                             logic [11:0] src, logic [11:0] dst);
      int s;
      int d;
      int q;
      fade_color_t r;
      case (mode)
        pfi_pkg::MODE_LOAD: begin
          for (int k = 0; k < 3; k++) begin
            s = ((int'(src) >> (4*k + 1)) & 7) << FRAC;
            d = ((int'(dst) >> (4*k + 1)) & 7) << FRAC;
            q = 0;
            if (frame_count != 0) q = (d - s) / int'(frame_count);
            chan_value[int'(entry)*3+k] = 16'(s) + ROUND_BIAS;
            chan_step[int'(entry)*3+k]  = 16'(q);
          end
        end
        pfi_pkg::MODE_START: begin
          if (frame_count == 0) begin
            r.color_index = first_index;
            r.color       = '0;
            r.last        = 1'b1;
            r.more_frames = 1'b0;
            r.status      = 1'b1;
            colors_due.push_back(r);
          end else begin
            frames_left = frame_count;
            queue_run(1'b0, 1'b1);
          end
        end
        pfi_pkg::MODE_FRAME: begin
          if (frames_left != 0) frames_left = frames_left - 1'b1;
          queue_run(1'b1, frames_left != 0);
        end
        default: ;
      endcase
    endfunction

    function void check_result(fade_color_t got);
      fade_color_t want;
      if (colors_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected color: idx %0d color %h last %b more %b status %b",
                   got.color_index, got.color, got.last, got.more_frames, got.status);
        return;
      end
      want = colors_due.pop_front();
      if (got.color_index !== want.color_index || got.color !== want.color ||
          got.last !== want.last || got.more_frames !== want.more_frames ||
          got.status !== want.status) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
          $display("color mismatch: want idx %0d color %h last %b more %b status %b",
                   want.color_index, want.color, want.last, want.more_frames, want.status);
          $display("                got  idx %0d color %h last %b more %b status %b",
                   got.color_index, got.color, got.last, got.more_frames, got.status);
        end
      end
    endfunction

    function int pending();
      return colors_due.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = pfi_pkg::CFG_FIRST_INDEX;
  logic [14:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_mode = pfi_pkg::MODE_LOAD;
  logic [5:0]  in_entry_index = '0;
  logic [11:0] in_source_color = '0;
  logic [11:0] in_target_color = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  out_color_index;
  logic [11:0] out_color;
  logic        out_last;
  logic        out_more_frames;
  logic        out_status;

  logic           quiet = 1'b0;
  int             item_count = 0;
  int             cycles = 0;
  fade_color_t    seen_color;
  fade_scoreboard sb;

  palette_fade_interpolator_unit u_top (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= rst_n && !quiet && ($urandom_range(0, 99) < 17);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_color.color_index = out_color_index;
      seen_color.color       = out_color;
      seen_color.last        = out_last;
      seen_color.more_frames = out_more_frames;
      seen_color.status      = out_status;
      sb.check_result(seen_color);
    end
  end

  task automatic send_item(input logic [1:0] mode, input logic [5:0] entry,
                           input logic [11:0] src, input logic [11:0] dst);
    if (!quiet) begin
      while ($urandom_range(0, 99) < 17) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_entry_index  <= entry;
    in_source_color <= src;
    in_target_color <= dst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(mode, entry, src, dst);
    if (mode != MODE_IGNORED) item_count++;
  endtask

  task automatic send_cmd(input logic [1:0] mode);
    send_item(mode, 6'($urandom), 12'($urandom), 12'($urandom));
  endtask

  task automatic load_random(input logic [5:0] entry);
    send_item(pfi_pkg::MODE_LOAD, entry, 12'($urandom), 12'($urandom));
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [14:0] data);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // registers only change once the block has drained
  task automatic set_config(input logic [5:0] first, input logic [6:0] count,
                            input logic [14:0] frames);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(pfi_pkg::CFG_FIRST_INDEX, 15'(first));
    write_reg(pfi_pkg::CFG_COLOR_COUNT, 15'(count));
    write_reg(pfi_pkg::CFG_FRAME_COUNT, frames);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic fade_phase();
    logic [5:0]  first;
    logic [6:0]  count;
    logic [14:0] frames;
    int          n;
    int          nframes;
    int          pick;
    first = 6'($urandom_range(0, 63));
    pick = $urandom_range(0, 19);
    if (pick == 0) count = 7'd64;
    else if (pick == 1) count = 7'd127;
    else if (pick == 2) count = 7'd0;
    else count = 7'($urandom_range(1, 8));
    pick = $urandom_range(0, 9);
    if (pick == 0) frames = 15'd0;
    else if (pick == 1) frames = 15'd32767;
    else if (pick == 2) frames = 15'($urandom_range(9, 32766));
    else frames = 15'($urandom_range(1, 6));
    n = (count == 0) ? 1 : (count > RUN_MAX) ? RUN_MAX : int'(count);
    nframes = (frames > 8) ? $urandom_range(2, 5) : int'(frames) + $urandom_range(0, 2);
    set_config(first, count, frames);
    for (int i = 0; i < n; i++) load_random(6'(i));
    if ($urandom_range(0, 9) != 0) send_cmd(pfi_pkg::MODE_START);
    for (int f = 0; f < nframes; f++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) send_cmd(MODE_IGNORED);
      else if (pick == 1) load_random(6'($urandom_range(0, 63)));
      else if (pick == 2) send_cmd(pfi_pkg::MODE_START);
      send_cmd(pfi_pkg::MODE_FRAME);
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // zero frame count: rejected start, zero steps, frame with counter at zero
    set_config(6'd63, 7'd4, 15'd0);
    send_item(pfi_pkg::MODE_LOAD, 6'd0, 12'h000, 12'hFFF);
    send_item(pfi_pkg::MODE_LOAD, 6'd1, 12'hFFF, 12'h000);
    send_item(pfi_pkg::MODE_LOAD, 6'd2, 12'hEEE, 12'h111);
    load_random(6'd3);
    send_cmd(pfi_pkg::MODE_START);
    send_cmd(MODE_IGNORED);
    send_cmd(pfi_pkg::MODE_FRAME);

    // single-frame fade, then one frame past the end
    set_config(6'd0, 7'd4, 15'd1);
    send_item(pfi_pkg::MODE_LOAD, 6'd0, 12'h000, 12'hEEE);
    send_item(pfi_pkg::MODE_LOAD, 6'd1, 12'hEEE, 12'h000);
    send_item(pfi_pkg::MODE_LOAD, 6'd2, 12'hFFF, 12'hFFF);
    load_random(6'd3);
    send_cmd(pfi_pkg::MODE_START);
    send_cmd(pfi_pkg::MODE_FRAME);
    send_cmd(pfi_pkg::MODE_FRAME);

    // color count of zero acts as one, longest fade
    set_config(6'd5, 7'd0, 15'd32767);
    send_item(pfi_pkg::MODE_LOAD, 6'd0, 12'h000, 12'hEEE);
    send_cmd(pfi_pkg::MODE_START);
    send_cmd(pfi_pkg::MODE_FRAME);

    // negative steps truncated toward zero
    set_config(6'd62, 7'd1, 15'd7);
    send_item(pfi_pkg::MODE_LOAD, 6'd0, 12'hEEE, 12'h000);
    send_cmd(pfi_pkg::MODE_START);
    send_cmd(pfi_pkg::MODE_FRAME);
    send_cmd(pfi_pkg::MODE_FRAME);

    for (int phase = 0; item_count < ITEM_TARGET; phase++) begin
      quiet <= (phase >= 6 && phase < 10);
      fade_phase();
    end
    quiet <= 1'b0;
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/pfi_pkg.sv
design/pfi_ram.sv
design/palette_fade_interpolator_unit.sv
tb/tb_palette_fade_interpolator_unit.sv
